@@ hdl/software_timer_table_macros.svh @@
// assertion helpers for the timer table
`ifndef SOFTWARE_TIMER_TABLE_MACROS_SVH
`define SOFTWARE_TIMER_TABLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SWTT_ASSERT_NOW(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define SWTT_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

@@ hdl/swtt_pkg.sv @@
package swtt_pkg;

   localparam int NUM_SLOTS_DEF = 16;
   // a tick never visits more than this many slots
   localparam int MAX_SCAN      = 16;

   localparam int PERIOD_W = 24;
   localparam int LIFE_W   = 24;
   localparam int ACC_W    = 32;
   localparam int DELTA_W  = 16;
   localparam int SLOT_W   = 4;

   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_ADD    = 2'd1;
   localparam logic [1:0] ACT_DELETE = 2'd2;

   localparam logic [1:0] MODE_LOOP  = 2'd0;
   localparam logic [1:0] MODE_ONCE  = 2'd1;
   localparam logic [1:0] MODE_TIMED = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } swtt_state_type;

   typedef struct packed {
      logic [1:0]          mode;
      logic [PERIOD_W-1:0] period;
      logic [LIFE_W-1:0]   lifetime;
      logic [ACC_W-1:0]    elapsed;
      logic [ACC_W-1:0]    life_elapsed;
   } swtt_entry_type;

   typedef struct packed {
      swtt_entry_type entry;
      logic           fired;
      logic           removed;
   } swtt_eval_type;

endpackage

@@ hdl/software_timer_table.sv @@
// Timer table with NUM_SLOTS slots (a tick serves at most the first sixteen).
// An add beat (tuser 1) of a known mode loads a slot with mode, period and
// lifetime and clears its accumulators; a delete beat (tuser 2) frees a slot;
// both, and any unknown action, get one acknowledge (rsp_tuser 0, tlast 1).
// A tick beat (tuser 0) adds delta to every active slot, visiting the slots
// in ascending order, and returns one event beat (rsp_tuser 1) per slot that
// fired or freed itself, tlast on the final one, or a single acknowledge if
// none did. Slot state lives in one synchronous memory with a registered read:
// the scan reads slot i+1 while it writes back slot i. A tick goes from the
// accept in ST_IDLE through ST_SCAN, visiting the slots, to ST_FLUSH; a stall
// on the result side holds the scan and the flush. Add and delete are taken
// only while the output register is free. There is no clearing pass after
// reset: of the slot state only the active bits are reset, and a slot's data
// is used only while the slot is active.

`include "software_timer_table_macros.svh"

module software_timer_table #(
   parameter int NUM_SLOTS = swtt_pkg::NUM_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // slot_id[3:0], timer_mode[5:4], period[29:6], lifetime[53:30], delta[69:54]
   input  logic [71:0] req_tdata,
   // action[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // event_slot[3:0], fired[4], removed[5]
   output logic [7:0]  rsp_tdata,
   // event_valid[0]
   output logic [0:0]  rsp_tuser,
   output logic        rsp_tlast
);

   localparam int IDX_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int SCAN_LEN = (NUM_SLOTS < swtt_pkg::MAX_SCAN) ? NUM_SLOTS
                                                                : swtt_pkg::MAX_SCAN;
   localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(SCAN_LEN - 1);
   localparam int SLOT_W = swtt_pkg::SLOT_W;

   // request fields
   logic [SLOT_W-1:0]                 req_slot_id;
   logic [1:0]                        req_timer_mode;
   logic [swtt_pkg::PERIOD_W-1:0]     req_period;
   logic [swtt_pkg::LIFE_W-1:0]       req_lifetime;
   logic [swtt_pkg::DELTA_W-1:0]      req_delta;

   assign req_slot_id    = req_tdata[3:0];
   assign req_timer_mode = req_tdata[5:4];
   assign req_period     = req_tdata[29:6];
   assign req_lifetime   = req_tdata[53:30];
   assign req_delta      = req_tdata[69:54];

   // slot memory, one read and one write port
   swtt_pkg::swtt_entry_type slot_mem [NUM_SLOTS];
   swtt_pkg::swtt_entry_type rd_data_ff;
   swtt_pkg::swtt_entry_type mem_wdata;
   logic [IDX_W-1:0]         mem_waddr;
   logic [IDX_W-1:0]         mem_raddr;
   logic                     mem_we;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= slot_mem[mem_raddr];
   end

   // control state
   swtt_pkg::swtt_state_type       state_ff, state_in;
   logic [NUM_SLOTS-1:0]           active_ff, active_in;
   logic [IDX_W-1:0]               scan_ff, scan_in;
   logic [swtt_pkg::DELTA_W-1:0]   delta_ff, delta_in;

   // held event, sent once the next event or the scan end tells its tlast
   logic                           pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]              pend_slot_ff, pend_slot_in;
   logic                           pend_fired_ff, pend_fired_in;
   logic                           pend_removed_ff, pend_removed_in;

   // output register
   logic                           out_valid_ff, out_valid_in;
   logic                           out_user_ff, out_user_in;
   logic [SLOT_W-1:0]              out_slot_ff, out_slot_in;
   logic                           out_fired_ff, out_fired_in;
   logic                           out_removed_ff, out_removed_in;
   logic                           out_last_ff, out_last_in;

   swtt_pkg::swtt_eval_type        eval;
   logic                           out_free;
   logic                           req_accept;
   logic                           id_in_range;
   logic [IDX_W-1:0]               id_idx;
   logic                           mode_known;
   logic                           cur_active;
   logic                           cur_event;
   logic                           stall;

   swtt_slot_alu u_alu (
      .entry  (rd_data_ff),
      .delta  (delta_ff),
      .result (eval)
   );

   assign out_free    = !out_valid_ff || rsp_tready;
   // no beat is taken while reset is held
   assign req_tready  = !reset && (state_ff == swtt_pkg::ST_IDLE) && out_free;
   assign req_accept  = req_tvalid && req_tready;
   assign id_in_range = (int'(req_slot_id) < NUM_SLOTS);
   assign id_idx      = IDX_W'(req_slot_id);
   assign mode_known  = (req_timer_mode == swtt_pkg::MODE_LOOP) ||
                        (req_timer_mode == swtt_pkg::MODE_ONCE) ||
                        (req_timer_mode == swtt_pkg::MODE_TIMED);
   assign cur_active  = active_ff[scan_ff];
   assign cur_event   = cur_active && (eval.fired || eval.removed);
   // a second event can only move on once the held one has a place to go
   assign stall       = cur_event && pend_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= swtt_pkg::ST_IDLE;
         active_ff     <= '0;
         scan_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         scan_ff       <= scan_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff        <= delta_in;
      pend_slot_ff    <= pend_slot_in;
      pend_fired_ff   <= pend_fired_in;
      pend_removed_ff <= pend_removed_in;
      out_user_ff     <= out_user_in;
      out_slot_ff     <= out_slot_in;
      out_fired_ff    <= out_fired_in;
      out_removed_ff  <= out_removed_in;
      out_last_ff     <= out_last_in;
   end

   always_comb begin
      state_in        = state_ff;
      active_in       = active_ff;
      scan_in         = scan_ff;
      delta_in        = delta_ff;
      pend_valid_in   = pend_valid_ff;
      pend_slot_in    = pend_slot_ff;
      pend_fired_in   = pend_fired_ff;
      pend_removed_in = pend_removed_ff;
      out_valid_in    = out_valid_ff && !rsp_tready;
      out_user_in     = out_user_ff;
      out_slot_in     = out_slot_ff;
      out_fired_in    = out_fired_ff;
      out_removed_in  = out_removed_ff;
      out_last_in     = out_last_ff;
      mem_we          = 1'b0;
      mem_waddr       = scan_ff;
      mem_wdata       = eval.entry;
      // idle reads slot 0 so a tick finds it ready on its first scan cycle
      mem_raddr       = '0;

      unique case (state_ff)
         swtt_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == swtt_pkg::ACT_TICK) begin
                  state_in      = swtt_pkg::ST_SCAN;
                  scan_in       = '0;
                  delta_in      = req_delta;
                  pend_valid_in = 1'b0;
               end else begin
                  if (req_tuser == swtt_pkg::ACT_ADD && id_in_range && mode_known) begin
                     mem_we                 = 1'b1;
                     mem_waddr              = id_idx;
                     mem_wdata.mode         = req_timer_mode;
                     mem_wdata.period       = req_period;
                     mem_wdata.lifetime     = req_lifetime;
                     mem_wdata.elapsed      = '0;
                     mem_wdata.life_elapsed = '0;
                     active_in[id_idx]      = 1'b1;
                  end
                  if (req_tuser == swtt_pkg::ACT_DELETE && id_in_range) begin
                     active_in[id_idx] = 1'b0;
                  end
                  // plain acknowledge
                  out_valid_in   = 1'b1;
                  out_user_in    = 1'b0;
                  out_slot_in    = '0;
                  out_fired_in   = 1'b0;
                  out_removed_in = 1'b0;
                  out_last_in    = 1'b1;
               end
            end
         end
         swtt_pkg::ST_SCAN: begin
            if (stall) begin
               // keep the current slot's data on the read port
               mem_raddr = scan_ff;
            end else begin
               if (cur_active) begin
                  mem_we = 1'b1;
                  if (eval.removed) begin
                     active_in[scan_ff] = 1'b0;
                  end
               end
               if (cur_event) begin
                  if (pend_valid_ff) begin
                     out_valid_in   = 1'b1;
                     out_user_in    = 1'b1;
                     out_slot_in    = pend_slot_ff;
                     out_fired_in   = pend_fired_ff;
                     out_removed_in = pend_removed_ff;
                     out_last_in    = 1'b0;
                  end
                  pend_valid_in   = 1'b1;
                  pend_slot_in    = SLOT_W'(scan_ff);
                  pend_fired_in   = eval.fired;
                  pend_removed_in = eval.removed;
               end
               if (scan_ff == SCAN_LAST) begin
                  state_in = swtt_pkg::ST_FLUSH;
               end else begin
                  scan_in   = scan_ff + IDX_W'(1);
                  mem_raddr = scan_ff + IDX_W'(1);
               end
            end
         end
         swtt_pkg::ST_FLUSH: begin
            if (out_free) begin
               out_valid_in   = 1'b1;
               out_last_in    = 1'b1;
               out_user_in    = pend_valid_ff;
               out_slot_in    = pend_valid_ff ? pend_slot_ff : '0;
               out_fired_in   = pend_valid_ff && pend_fired_ff;
               out_removed_in = pend_valid_ff && pend_removed_ff;
               pend_valid_in  = 1'b0;
               state_in       = swtt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swtt_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_removed_ff, out_fired_ff, out_slot_ff};
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

   // checks
   `SWTT_ASSERT_NEXT(a_tick_starts_scan, req_accept && req_tuser == swtt_pkg::ACT_TICK, state_ff == swtt_pkg::ST_SCAN, "accepted tick did not start a scan")
   `SWTT_ASSERT_NOW(a_ack_is_last, rsp_tvalid && !rsp_tuser[0], rsp_tlast && rsp_tdata == 8'h00, "acknowledge beat not final or not empty")
   `SWTT_ASSERT_NOW(a_event_has_cause, rsp_tvalid && rsp_tuser[0], rsp_tdata[4] || rsp_tdata[5], "event beat with neither fired nor removed")
   `SWTT_ASSERT_NEXT(a_flush_ends_tick, state_ff == swtt_pkg::ST_FLUSH && out_free, rsp_tvalid && rsp_tlast && !pend_valid_ff, "flush did not close the tick")

endmodule

@@ hdl/swtt_slot_alu.sv @@
module swtt_slot_alu (
   input  swtt_pkg::swtt_entry_type          entry,
   input  logic [swtt_pkg::DELTA_W-1:0]      delta,
   output swtt_pkg::swtt_eval_type           result
);

   localparam int ACC_W = swtt_pkg::ACC_W;

   logic [ACC_W:0]   el_sum;
   logic [ACC_W:0]   life_sum;
   logic [ACC_W-1:0] el_sat;
   logic [ACC_W-1:0] life_sat;
   logic [ACC_W-1:0] period_ext;
   logic [ACC_W-1:0] life_ext;
   logic [ACC_W-1:0] el_sub;
   logic             reach;
   logic             life_reach;

   // saturating accumulate
   assign el_sum   = {1'b0, entry.elapsed} + (ACC_W + 1)'(delta);
   assign life_sum = {1'b0, entry.life_elapsed} + (ACC_W + 1)'(delta);
   assign el_sat   = el_sum[ACC_W] ? '1 : el_sum[ACC_W-1:0];
   assign life_sat = life_sum[ACC_W] ? '1 : life_sum[ACC_W-1:0];

   assign period_ext = ACC_W'(entry.period);
   assign life_ext   = ACC_W'(entry.lifetime);
   assign reach      = (el_sat >= period_ext);
   assign life_reach = (life_sat >= life_ext);
   assign el_sub     = el_sat - period_ext;

   always_comb begin
      result               = '0;
      result.entry         = entry;
      result.entry.elapsed = el_sat;
      case (entry.mode)
         swtt_pkg::MODE_LOOP: begin
            result.fired = reach;
            if (reach) begin
               result.entry.elapsed = el_sub;
            end
         end
         swtt_pkg::MODE_ONCE: begin
            result.fired   = reach;
            result.removed = reach;
         end
         default: begin
            result.entry.life_elapsed = life_sat;
            result.fired              = reach;
            result.removed            = life_reach;
            if (reach) begin
               result.entry.elapsed = el_sub;
            end
         end
      endcase
   end

endmodule

@@ tb/sv/tb_software_timer_table.sv @@
`timescale 1ns / 100ps

module tb_software_timer_table;

   localparam int NUM_SLOTS_DEF = swtt_pkg::NUM_SLOTS_DEF;
   localparam int MAX_SCAN      = swtt_pkg::MAX_SCAN;
   localparam int PERIOD_W      = swtt_pkg::PERIOD_W;
   localparam int LIFE_W        = swtt_pkg::LIFE_W;
   localparam int ACC_W         = swtt_pkg::ACC_W;
   localparam int DELTA_W       = swtt_pkg::DELTA_W;
   localparam int SLOT_W        = swtt_pkg::SLOT_W;

   // codes the package leaves unnamed
   localparam logic [1:0] ACT_UNUSED  = 2'd3;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam int TOTAL_REQS  = 370;
   localparam int QUIET_REQS  = 40;  // no idling while this few are left
   localparam int HOLD_CYCLES = 300; // long result-side hold-off
   localparam int DRAIN_WAIT  = 40;  // cycles after the last expected beat

   typedef struct {
      logic [1:0]          action;
      logic [SLOT_W-1:0]   slot_id;
      logic [1:0]          mode;
      logic [PERIOD_W-1:0] period;
      logic [LIFE_W-1:0]   lifetime;
      logic [DELTA_W-1:0]  delta;
   } timer_req_type;

   typedef struct {
      logic              event_valid;
      logic [SLOT_W-1:0] event_slot;
      logic              fired;
      logic              removed;
      logic              last;
   } timer_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [1:0]  req_tuser = swtt_pkg::ACT_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;

   software_timer_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // predicted copy of the slot table
   logic                slot_live      [NUM_SLOTS_DEF];
   logic [1:0]          slot_kind      [NUM_SLOTS_DEF];
   logic [PERIOD_W-1:0] slot_interval  [NUM_SLOTS_DEF];
   logic [LIFE_W-1:0]   slot_life_limit[NUM_SLOTS_DEF];
   logic [ACC_W-1:0]    slot_acc       [NUM_SLOTS_DEF];
   logic [ACC_W-1:0]    slot_life_acc  [NUM_SLOTS_DEF];

   timer_req_type  pending_requests[$];
   timer_beat_type expected_events[$];
   timer_req_type  held_req;
   int             send_gap = 0;
   int             stall_left = 0;
   int             beats_accepted = 0;
   int             mismatch_count = 0;
   logic           quiet_tail = 1'b0;
   logic           hold_rsp = 1'b0;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   // accumulator add that sticks at all ones
   function automatic logic [ACC_W-1:0] sat_sum(input logic [ACC_W-1:0] a,
                                                input logic [DELTA_W-1:0] d);
      logic [ACC_W:0] s;
      s = {1'b0, a} + (ACC_W + 1)'(d);
      return s[ACC_W] ? '1 : s[ACC_W-1:0];
   endfunction

   // apply one request beat to the table copy and queue the beats it causes
   function automatic void predict_timer_beats(input timer_req_type rq);
      timer_beat_type beats[$];
      timer_beat_type b;
      logic           hit;
      logic           gone;
      if (rq.action == swtt_pkg::ACT_ADD) begin
         if (rq.slot_id < NUM_SLOTS_DEF && rq.mode <= swtt_pkg::MODE_TIMED) begin
            slot_live[rq.slot_id]       = 1'b1;
            slot_kind[rq.slot_id]       = rq.mode;
            slot_interval[rq.slot_id]   = rq.period;
            slot_life_limit[rq.slot_id] = rq.lifetime;
            slot_acc[rq.slot_id]        = '0;
            slot_life_acc[rq.slot_id]   = '0;
         end
      end else if (rq.action == swtt_pkg::ACT_DELETE) begin
         if (rq.slot_id < NUM_SLOTS_DEF) slot_live[rq.slot_id] = 1'b0;
      end else if (rq.action == swtt_pkg::ACT_TICK) begin
         for (int i = 0; i < NUM_SLOTS_DEF && i < MAX_SCAN; i++) begin
            if (slot_live[i]) begin
               hit  = 1'b0;
               gone = 1'b0;
               slot_acc[i] = sat_sum(slot_acc[i], rq.delta);
               case (slot_kind[i])
                  swtt_pkg::MODE_LOOP: begin
                     if (slot_acc[i] >= slot_interval[i]) begin
                        hit = 1'b1;
                        slot_acc[i] = slot_acc[i] - ACC_W'(slot_interval[i]);
                     end
                  end
                  swtt_pkg::MODE_ONCE: begin
                     if (slot_acc[i] >= slot_interval[i]) begin
                        hit  = 1'b1;
                        gone = 1'b1;
                     end
                  end
                  default: begin
                     slot_life_acc[i] = sat_sum(slot_life_acc[i], rq.delta);
                     if (slot_acc[i] >= slot_interval[i]) begin
                        hit = 1'b1;
                        slot_acc[i] = slot_acc[i] - ACC_W'(slot_interval[i]);
                     end
                     if (slot_life_acc[i] >= slot_life_limit[i]) gone = 1'b1;
                  end
               endcase
               if (gone) slot_live[i] = 1'b0;
               if (hit || gone)
                  beats.insert(beats.size(), '{1'b1, SLOT_W'(i), hit, gone, 1'b0});
            end
         end
      end
      // a tick with no event, and every other beat, gets one acknowledge
      if (beats.size() == 0) begin
         beats.insert(0, '{1'b0, '0, 1'b0, 1'b0, 1'b1});
      end
      for (int k = 0; k < beats.size(); k++) begin
         b = beats[k];
         b.last = (k == beats.size() - 1);
         expected_events.insert(expected_events.size(), b);
      end
   endfunction

   // fields that the action does not use carry random bits
   function automatic timer_req_type noise_req();
      timer_req_type r;
      r.action   = 2'($urandom);
      r.slot_id  = SLOT_W'($urandom);
      r.mode     = 2'($urandom);
      r.period   = PERIOD_W'($urandom);
      r.lifetime = LIFE_W'($urandom);
      r.delta    = DELTA_W'($urandom);
      return r;
   endfunction

   task automatic queue_tick(input logic [DELTA_W-1:0] d);
      timer_req_type r;
      r = noise_req();
      r.action = swtt_pkg::ACT_TICK;
      r.delta  = d;
      pending_requests.insert(pending_requests.size(), r);
   endtask

   task automatic queue_add(input logic [SLOT_W-1:0] s, input logic [1:0] m,
                            input logic [PERIOD_W-1:0] p, input logic [LIFE_W-1:0] l);
      timer_req_type r;
      r = noise_req();
      r.action   = swtt_pkg::ACT_ADD;
      r.slot_id  = s;
      r.mode     = m;
      r.period   = p;
      r.lifetime = l;
      pending_requests.insert(pending_requests.size(), r);
   endtask

   task automatic queue_delete(input logic [SLOT_W-1:0] s);
      timer_req_type r;
      r = noise_req();
      r.action  = swtt_pkg::ACT_DELETE;
      r.slot_id = s;
      pending_requests.insert(pending_requests.size(), r);
   endtask

   task automatic queue_unknown();
      timer_req_type r;
      r = noise_req();
      r.action = ACT_UNUSED;
      pending_requests.insert(pending_requests.size(), r);
   endtask

   // mostly small deltas so that periods elapse, now and then a huge one
   function automatic logic [DELTA_W-1:0] pick_delta();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return DELTA_W'($urandom_range(0, 20));
      if (r < 95) return DELTA_W'($urandom_range(0, 300));
      return DELTA_W'($urandom);
   endfunction

   function automatic logic [PERIOD_W-1:0] pick_period();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return PERIOD_W'($urandom_range(0, 40));
      if (r < 90) return PERIOD_W'($urandom_range(0, 1000));
      return PERIOD_W'($urandom);
   endfunction

   function automatic logic [LIFE_W-1:0] pick_lifetime();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return LIFE_W'($urandom_range(0, 150));
      if (r < 90) return LIFE_W'($urandom_range(0, 5000));
      return LIFE_W'($urandom);
   endfunction

   function automatic logic [1:0] pick_mode();
      if ($urandom_range(0, 19) == 0) return MODE_UNUSED;
      return 2'($urandom_range(0, 2));
   endfunction

   // request list: directed corner cases, then random traffic
   initial begin
      int r;
      queue_tick(16'd0);                                        // empty table
      queue_add(4'd0, swtt_pkg::MODE_LOOP, 24'd0, 24'd0);       // zero period
      queue_tick(16'd0);                                        // fires on zero delta
      queue_add(4'd15, swtt_pkg::MODE_ONCE, 24'hFFFFFF, 24'hFFFFFF);
      queue_add(4'd1, swtt_pkg::MODE_TIMED, 24'd3, 24'd0);      // zero lifetime
      queue_tick(16'hFFFF);
      queue_add(4'd2, swtt_pkg::MODE_TIMED, 24'hFFFFFF, 24'hFFFFFF);
      queue_add(4'd3, MODE_UNUSED, 24'd1, 24'd1);               // unknown mode, ignored
      queue_unknown();
      queue_delete(4'd4);                                       // free slot
      queue_delete(4'd0);
      queue_add(4'd5, swtt_pkg::MODE_ONCE, 24'd10, 24'd0);
      queue_tick(16'd10);
      queue_add(4'd15, swtt_pkg::MODE_LOOP, 24'd1, 24'd0);      // overwrite a live slot
      queue_tick(16'd0);
      queue_tick(16'd1);
      queue_delete(4'd15);
      queue_delete(4'd2);
      queue_add(4'd7, swtt_pkg::MODE_TIMED, 24'd5, 24'd5);      // fire and expire together
      queue_tick(16'd5);
      queue_tick(16'd3);

      while (pending_requests.size() < TOTAL_REQS) begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            // fill every slot, then tick a few times for long event trains
            for (int k = 0; k < NUM_SLOTS_DEF; k++)
               queue_add(SLOT_W'(k), 2'($urandom_range(0, 2)),
                         PERIOD_W'($urandom_range(0, 8)), LIFE_W'($urandom_range(0, 60)));
            repeat (3) queue_tick(DELTA_W'($urandom_range(0, 10)));
         end else if (r < 47) begin
            queue_tick(pick_delta());
         end else if (r < 80) begin
            queue_add(SLOT_W'($urandom), pick_mode(), pick_period(), pick_lifetime());
         end else if (r < 93) begin
            queue_delete(SLOT_W'($urandom));
         end else begin
            queue_unknown();
         end
      end
   end

   // request driver
   always @(posedge clock) begin : req_driver
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            predict_timer_beats(held_req);
            beats_accepted++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_requests.size() > 0) begin
               if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                  send_gap = $urandom_range(1, 5) - 1;
               end else begin
                  held_req = pending_requests.pop_front();
                  next_valid = 1'b1;
                  req_tdata <= {2'b00, held_req.delta, held_req.lifetime,
                                held_req.period, held_req.mode, held_req.slot_id};
                  req_tuser <= held_req.action;
               end
            end
         end
         req_tvalid <= next_valid;
         quiet_tail <= (pending_requests.size() < QUIET_REQS);
      end
   end

   // result monitor and checker
   always @(posedge clock) begin : rsp_monitor
      timer_beat_type got;
      timer_beat_type want;
      logic           next_ready;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tuser[0], rsp_tdata[3:0], rsp_tdata[4], rsp_tdata[5], rsp_tlast};
            if (expected_events.size() == 0) begin
               report_mismatch($sformatf("unexpected beat %p", got));
            end else begin
               want = expected_events.pop_front();
               if (got.event_valid !== want.event_valid || got.event_slot !== want.event_slot ||
                   got.fired !== want.fired || got.removed !== want.removed ||
                   got.last !== want.last)
                  report_mismatch($sformatf("got %p, want %p", got, want));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
         rsp_tready <= next_ready && !hold_rsp;
      end
   end

   // one long hold-off on the result side so the block backs up
   initial begin
      wait (beats_accepted >= 60);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      @(negedge reset);
      while (pending_requests.size() != 0 || req_tvalid || expected_events.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("FAILURE");
      $finish;
   end

endmodule
